[rtl/tnfp_pkg.sv]
// ============================================================================
// tnfp_pkg - shared types and constants of the typed numeric field parser
// Holds the item structs, the type codes, the character codes and the per-type
// digit limit and width mask used by the front and back halves of the parser.
// ============================================================================
package tnfp_pkg;

    // Type codes carried in the mode field
    typedef enum logic [3:0] {
        MODE_I8    = 4'd0,
        MODE_U8    = 4'd1,
        MODE_I16   = 4'd2,
        MODE_U16   = 4'd3,
        MODE_I32   = 4'd4,
        MODE_U32   = 4'd5,
        MODE_H8    = 4'd6,
        MODE_H16   = 4'd7,
        MODE_H32   = 4'd8,
        MODE_CHAR  = 4'd9,
        MODE_UCHAR = 4'd10
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MISSING   = 2'd1,
        ST_NO_COMMA  = 2'd2,
        ST_OUT_LIMIT = 2'd3
    } t_status;

    // Character codes
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_COMMA = 8'd44;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_0     = 8'd48;
    localparam logic [7:0] CHAR_9     = 8'd57;
    localparam logic [7:0] CHAR_UA    = 8'd65;
    localparam logic [7:0] CHAR_UF    = 8'd70;
    localparam logic [7:0] CHAR_LA    = 8'd97;
    localparam logic [7:0] CHAR_LF    = 8'd102;
    localparam logic [7:0] CHAR_LZ    = 8'd122;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    // Letter A..F has low nibble 1..6; adding nine gives 10..15.
    localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

    // Range limits
    localparam logic [31:0] I8_NEG_MAX  = 32'h0000_0080;
    localparam logic [31:0] I16_NEG_MAX = 32'h0000_8000;
    localparam logic [31:0] I32_NEG_MAX = 32'h8000_0000;
    localparam logic [31:0] I8_POS_MAX  = 32'h0000_007F;
    localparam logic [31:0] U8_MAX      = 32'h0000_00FF;
    localparam logic [31:0] I16_POS_MAX = 32'h0000_7FFF;
    localparam logic [31:0] U16_MAX     = 32'h0000_FFFF;
    localparam logic [31:0] I32_POS_MAX = 32'h7FFF_FFFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input item
    typedef struct packed {
        logic [7:0] char_byte;
        logic       field_start;
        logic [3:0] mode;
        logic       optional_field;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic        byte_consumed;
        logic        report_error;
    } t_out_item;

    // Classified item passed from front to back
    typedef struct packed {
        logic [7:0] char_byte;
        logic       field_start;
        logic [3:0] mode;
        logic       optional_field;
        logic       is_cr;
        logic       is_comma;
        logic       is_minus;
        logic       is_lower;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] dec_val;
        logic [3:0] hex_val;
    } t_cls_item;

    // Field end record handed to the range check stage
    typedef struct packed {
        logic        chk;
        logic [1:0]  status;
        logic [31:0] value;
        logic        byte_consumed;
        logic        report_error;
        logic        neg;
        logic [3:0]  ltype;
    } t_fin_item;

    // Number of digits that ends a numeric field
    function automatic logic [3:0] digit_limit(input logic [3:0] t);
        logic [3:0] lim;
        unique case (t)
            MODE_I8, MODE_U8:   lim = 4'd3;
            MODE_I16, MODE_U16: lim = 4'd5;
            MODE_I32, MODE_U32: lim = 4'd10;
            MODE_H8:            lim = 4'd2;
            MODE_H16:           lim = 4'd4;
            MODE_H32:           lim = 4'd8;
            default:            lim = 4'd0;
        endcase
        return lim;
    endfunction

    // Bit mask of the type width
    function automatic logic [31:0] type_mask(input logic [3:0] t);
        logic [31:0] m;
        unique case (t)
            MODE_I8, MODE_U8, MODE_H8, MODE_CHAR, MODE_UCHAR: m = 32'h0000_00FF;
            MODE_I16, MODE_U16, MODE_H16:                     m = 32'h0000_FFFF;
            default:                                          m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

[rtl/tnfp_front.sv]
// ============================================================================
// tnfp_front - byte classifier
// Decodes each incoming byte into the character classes and digit values that
// the back half needs, so that the back half only selects and accumulates.
// ============================================================================
module tnfp_front import tnfp_pkg::*; (
    input  t_in_item  i_item,
    output t_cls_item o_cls
);

    logic [7:0] b;
    logic       is_upper_hex;
    logic       is_lower_hex;

    assign b = i_item.char_byte;

    // Letter ranges for hex digits
    assign is_upper_hex = (b >= CHAR_UA) && (b <= CHAR_UF);
    assign is_lower_hex = (b >= CHAR_LA) && (b <= CHAR_LF);

    // Classified item
    always_comb begin
        o_cls.char_byte      = b;
        o_cls.field_start    = i_item.field_start;
        o_cls.mode           = i_item.mode;
        o_cls.optional_field = i_item.optional_field;
        o_cls.is_cr          = (b == CHAR_CR);
        o_cls.is_comma       = (b == CHAR_COMMA);
        o_cls.is_minus       = (b == CHAR_MINUS);
        o_cls.is_lower       = (b >= CHAR_LA) && (b <= CHAR_LZ);
        o_cls.dec_ok         = (b >= CHAR_0) && (b <= CHAR_9);
        o_cls.hex_ok         = o_cls.dec_ok || is_upper_hex || is_lower_hex;
        o_cls.dec_val        = b[3:0];
        o_cls.hex_val        = o_cls.dec_ok ? b[3:0] : b[3:0] + HEX_LETTER_OFS;
    end

endmodule

[rtl/tnfp_queue.sv]
// ============================================================================
// tnfp_queue - classified item queue
// A short first-in first-out queue that decouples the classifier from the
// parsing state machine so that each side can stall on its own.
// ============================================================================
module tnfp_queue import tnfp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_item i_wdata,
    input  logic      i_pop,
    output t_cls_item o_rdata,
    output logic      o_empty,
    output logic      o_full
);

    t_cls_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/tnfp_back.sv]
// ============================================================================
// tnfp_back - parsing state machine, range check and output register
// Takes one classified item per unstalled cycle, runs the field phases and the
// accumulator, then range-checks a finished field and holds the result item.
// ============================================================================
module tnfp_back import tnfp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cls_item i_cls,
    input  logic      i_cls_avail,
    output logic      o_cls_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [31:0] r_acc,    n_acc;
    logic        r_neg,    n_neg;
    logic [3:0]  r_digits, n_digits;
    logic [3:0]  r_ltype,  n_ltype;
    logic        r_lopt,   n_lopt;
    logic        r_fin_valid, n_fin_valid;
    t_fin_item   r_fin,       n_fin;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out,       n_out;

    logic        out_ready;
    logic        fin_ready;
    logic        pop;
    logic        emit;
    t_fin_item   emit_rec;
    logic        do_digit;
    logic        dig_ok;
    logic [31:0] dig_acc;
    logic [3:0]  dig_cnt;
    logic [3:0]  ctype;
    logic        bad;
    logic [31:0] a;

    // Pipeline advance
    assign out_ready = !r_out_valid || !i_out_stall;
    assign fin_ready = !r_fin_valid || out_ready;
    assign pop       = i_cls_avail && fin_ready;
    assign o_cls_pop = pop;

    // Digit accumulation for the type in effect
    always_comb begin
        ctype   = r_ltype;
        dig_ok  = (ctype >= MODE_H8) ? i_cls.hex_ok : i_cls.dec_ok;
        if (ctype >= MODE_H8) begin
            dig_acc = {r_acc[27:0], i_cls.hex_val};
        end else begin
            dig_acc = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + {28'd0, i_cls.dec_val};
        end
        dig_cnt = r_digits + 4'd1;
    end

    // Phase machine for one item
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_digits = r_digits;
        n_ltype  = r_ltype;
        n_lopt   = r_lopt;
        emit     = 1'b0;
        do_digit = 1'b0;
        emit_rec = '{chk: 1'b0, status: ST_OK, value: 32'd0, byte_consumed: 1'b0,
                     report_error: 1'b0, neg: 1'b0, ltype: 4'd0};
        if (i_cls.field_start) begin
            n_ltype  = i_cls.mode;
            n_lopt   = i_cls.optional_field;
            n_acc    = '0;
            n_neg    = 1'b0;
            n_digits = '0;
            if (i_cls.is_cr) begin
                emit                  = 1'b1;
                emit_rec.status       = ST_MISSING;
                emit_rec.report_error = !i_cls.optional_field;
            end else if (!i_cls.is_comma) begin
                emit                  = 1'b1;
                emit_rec.status       = ST_NO_COMMA;
                emit_rec.report_error = !i_cls.optional_field;
            end else begin
                n_phase = PH_SIGN;
            end
        end else if (r_phase == PH_SIGN) begin
            if (i_cls.is_cr) begin
                emit                  = 1'b1;
                emit_rec.status       = ST_MISSING;
                emit_rec.report_error = !r_lopt;
            end else if (r_ltype > MODE_UCHAR) begin
                emit            = 1'b1;
                emit_rec.status = ST_OUT_LIMIT;
            end else if (r_ltype >= MODE_CHAR) begin
                // Single character field, uppercased for the upper char type
                emit                   = 1'b1;
                emit_rec.byte_consumed = 1'b1;
                emit_rec.value         = {24'd0, i_cls.char_byte};
                if (r_ltype == MODE_UCHAR && i_cls.is_lower) begin
                    emit_rec.value = {24'd0, i_cls.char_byte & ~CASE_BIT};
                end
            end else if (i_cls.is_minus) begin
                if (r_ltype == MODE_U8 || r_ltype == MODE_U16 ||
                    r_ltype == MODE_U32 || r_ltype == MODE_H32) begin
                    emit                  = 1'b1;
                    emit_rec.status       = ST_OUT_LIMIT;
                    emit_rec.report_error = 1'b1;
                end else begin
                    n_neg   = 1'b1;
                    n_phase = PH_DIGITS;
                end
            end else begin
                n_phase  = PH_DIGITS;
                do_digit = 1'b1;
            end
        end else if (r_phase == PH_DIGITS && r_ltype <= MODE_H32) begin
            do_digit = 1'b1;
        end else begin
            n_phase = PH_IDLE;
        end

        // Digit step: a non-digit or the last allowed digit ends the field
        if (do_digit) begin
            emit_rec.chk   = 1'b1;
            emit_rec.neg   = r_neg;
            emit_rec.ltype = r_ltype;
            if (!dig_ok) begin
                emit           = 1'b1;
                emit_rec.value = r_acc;
            end else begin
                n_acc    = dig_acc;
                n_digits = dig_cnt;
                if (dig_cnt >= digit_limit(r_ltype)) begin
                    emit                   = 1'b1;
                    emit_rec.value         = dig_acc;
                    emit_rec.byte_consumed = 1'b1;
                end
            end
        end

        if (emit) begin
            n_phase = PH_IDLE;
        end
    end

    // Range check, sign and width of a finished field
    always_comb begin
        a = r_fin.value;
        if (r_fin.neg) begin
            bad = (r_fin.ltype == MODE_I8  && a > I8_NEG_MAX) ||
                  (r_fin.ltype == MODE_I16 && a > I16_NEG_MAX) ||
                  (r_fin.ltype == MODE_I32 && a > I32_NEG_MAX);
        end else begin
            bad = (r_fin.ltype == MODE_I8  && a > I8_POS_MAX) ||
                  (r_fin.ltype == MODE_U8  && a > U8_MAX) ||
                  (r_fin.ltype == MODE_I16 && a > I16_POS_MAX) ||
                  (r_fin.ltype == MODE_U16 && a > U16_MAX) ||
                  (r_fin.ltype == MODE_I32 && a > I32_POS_MAX);
        end
        n_out.byte_consumed = r_fin.byte_consumed;
        if (!r_fin.chk) begin
            n_out.status       = r_fin.status;
            n_out.value        = r_fin.value;
            n_out.report_error = r_fin.report_error;
        end else if (bad) begin
            n_out.status       = ST_OUT_LIMIT;
            n_out.value        = '0;
            n_out.report_error = 1'b1;
        end else begin
            n_out.status       = ST_OK;
            n_out.value        = (r_fin.neg ? (32'd0 - a) : a) & type_mask(r_fin.ltype);
            n_out.report_error = 1'b0;
        end
    end

    // Stage loads
    always_comb begin
        n_fin_valid = r_fin_valid;
        n_fin       = r_fin;
        n_out_valid = r_out_valid;
        if (out_ready) begin
            n_out_valid = r_fin_valid;
        end
        if (fin_ready) begin
            n_fin_valid = pop && emit;
            n_fin       = emit_rec;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_digits    <= '0;
            r_ltype     <= '0;
            r_lopt      <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_neg    <= n_neg;
                r_digits <= n_digits;
                r_ltype  <= n_ltype;
                r_lopt   <= n_lopt;
            end
            r_fin_valid <= n_fin_valid;
            r_out_valid <= n_out_valid;
        end
        r_fin <= n_fin;
        if (out_ready) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A comma at a field start always opens the sign phase.
    a_comma_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_cls.field_start && i_cls.is_comma |=> r_phase == PH_SIGN)
        else $error("comma at field start did not open the sign phase");

    // The digit count never passes the largest per-type limit.
    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits <= 4'd10)
        else $error("digit count passed the largest limit");

    // Only numeric types reach the digit phase.
    a_digit_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DIGITS |-> r_ltype <= MODE_H32)
        else $error("non-numeric type in digit phase");

    // A failed field always reports a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_OK |-> r_out.value == 32'd0)
        else $error("error result carries a nonzero value");

endmodule

[rtl/typed_numeric_field_parser.sv]
// ============================================================================
// typed_numeric_field_parser - comma-prefixed typed parameter parser
// Reads one parameter of a command line a byte at a time and returns its
// status, range-checked value and whether the ending byte was used.
// ============================================================================
// The parser takes one byte per clock cycle and sustains that rate as long as
// the result side is not stalled. Each byte is classified on entry and placed
// in a four-item queue; the parsing state machine takes one item a cycle from
// the queue, and a finished field passes a range check stage and an output
// register, which presents the result item. Input stall rises only when the
// queue holds four items.
// Bytes that do not end a field produce no result item.
module typed_numeric_field_parser import tnfp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cls_item cls_in;
    t_cls_item cls_out;
    logic      q_empty;
    logic      q_full;
    logic      q_pop;

    // Byte classification
    tnfp_front u_front (
        .i_item (i_in_item),
        .o_cls  (cls_in)
    );

    // Decoupling queue
    tnfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_wdata (cls_in),
        .i_pop   (q_pop),
        .o_rdata (cls_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign o_in_stall = q_full;

    // Parsing and result delivery
    tnfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (cls_out),
        .i_cls_avail (!q_empty),
        .o_cls_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
